### rtl/core/hcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcd_pkg: shared types and constants of the chunked body decoder
// Phase codes, control state, result record and the hex digit decode.
// ---------------------------------------------------------------------------
package hcd_pkg;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam int         HEX_SHIFT = 4;

	typedef enum logic [2:0] {
		PH_SIZE = 3'b001,
		PH_DATA = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic   line_has_text;
		logic   after_return;
	} ctrl_t;

	localparam ctrl_t CTRL_RESET = '{phase: PH_SIZE, line_has_text: 1'b0, after_return: 1'b0};

	typedef struct packed {
		logic       valid;
		logic [7:0] payload;
		logic       eob;
	} res_t;

	typedef struct packed {
		logic                 ok;
		logic [HEX_SHIFT-1:0] value;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok    = 1'b1;
			h.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.ok    = 1'b1;
			h.value = 4'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.ok    = 1'b1;
			h.value = 4'(c - 8'h41 + 8'd10);
		end
		return h;
	endfunction

endpackage
`default_nettype wire

### rtl/core/hcd_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcd_step: chunk framing update for one byte
// Next decoder state and the optional result for one received byte.
// ---------------------------------------------------------------------------
module hcd_step
	import hcd_pkg::*;
#(
	parameter int SIZE_BITS = 32
) (
	input  ctrl_t                ctrl,
	input  logic [SIZE_BITS-1:0] bytes_left,
	input  logic [SIZE_BITS-1:0] size_accum,
	input  logic [7:0]           in_byte,
	input  logic                 new_message,
	output ctrl_t                ctrl_nxt,
	output logic [SIZE_BITS-1:0] bytes_left_nxt,
	output logic [SIZE_BITS-1:0] size_accum_nxt,
	output res_t                 res
);

	ctrl_t                cur_ctrl;
	logic [SIZE_BITS-1:0] cur_left;
	logic [SIZE_BITS-1:0] cur_acc;
	logic [SIZE_BITS-1:0] left_dec;
	hex_t                 hex;

	assign hex      = hex_digit(in_byte);
	assign left_dec = cur_left - SIZE_BITS'(1);

	always_comb begin
		cur_ctrl = ctrl;
		cur_left = bytes_left;
		cur_acc  = size_accum;
		// new message: start from a clean state before this byte
		if (new_message) begin
			cur_ctrl = CTRL_RESET;
			cur_left = '0;
			cur_acc  = '0;
		end
	end

	always_comb begin
		ctrl_nxt       = cur_ctrl;
		bytes_left_nxt = cur_left;
		size_accum_nxt = cur_acc;
		res            = '0;
		unique case (cur_ctrl.phase)
			PH_DATA: begin
				res.valid      = 1'b1;
				res.payload    = in_byte;
				bytes_left_nxt = left_dec;
				if (left_dec == '0) begin
					ctrl_nxt.phase = PH_SIZE;
				end
			end
			PH_SIZE: begin
				if (in_byte == CH_LF) begin
					ctrl_nxt.line_has_text = 1'b0;
					ctrl_nxt.after_return  = 1'b0;
					size_accum_nxt         = '0;
					// empty lines are skipped
					if (cur_ctrl.line_has_text) begin
						if (cur_acc == '0) begin
							ctrl_nxt.phase = PH_DONE;
							res.valid      = 1'b1;
							res.eob        = 1'b1;
						end else begin
							bytes_left_nxt = cur_acc;
							ctrl_nxt.phase = PH_DATA;
						end
					end
				end else if (!cur_ctrl.after_return) begin
					if (in_byte == CH_CR) begin
						ctrl_nxt.after_return = 1'b1;
					end else begin
						ctrl_nxt.line_has_text = 1'b1;
						// a non-hex byte ends the size text like an extension
						if (!hex.ok) begin
							ctrl_nxt.after_return = 1'b1;
						end else begin
							size_accum_nxt = {cur_acc[SIZE_BITS-HEX_SHIFT-1:0], hex.value};
						end
					end
				end
			end
			default: begin
				// body done: drop bytes until a new message
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer decoding
// Strips chunk size lines from a chunked body and forwards payload bytes.
// ---------------------------------------------------------------------------
// One body byte per request, one request per clock cycle at full rate. A byte
// is held in an input register, the chunk framing state is updated in a single
// combinational pass (hex shift, size compare, one SIZE_BITS-wide decrement)
// and the result lands in an output register. Size lines, the CRLF closing
// each chunk and bytes after the last chunk give no result; the zero-size
// line gives one result with end_of_body set and payload_byte zero.
// new_message clears all state before its byte is handled. The input register
// keeps taking requests while a result waits, and stalls only when both
// registers are full.
module http_chunked_body_decoder
	import hcd_pkg::*;
#(
	parameter int SIZE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       new_message,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       end_of_body
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 new_msg_s1;
	logic                 go_s1;

	ctrl_t                ctrl_q;
	logic [SIZE_BITS-1:0] bytes_left_q;
	logic [SIZE_BITS-1:0] size_accum_q;

	ctrl_t                ctrl_nxt;
	logic [SIZE_BITS-1:0] bytes_left_nxt;
	logic [SIZE_BITS-1:0] size_accum_nxt;
	res_t                 res;

	logic                 out_valid_q;
	logic [7:0]           payload_q;
	logic                 eob_q;

	assign go_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1    <= in_byte;
			new_msg_s1 <= new_message;
		end
	end

	hcd_step #(
		.SIZE_BITS(SIZE_BITS)
	) u_step (
		.ctrl          (ctrl_q),
		.bytes_left    (bytes_left_q),
		.size_accum    (size_accum_q),
		.in_byte       (byte_s1),
		.new_message   (new_msg_s1),
		.ctrl_nxt      (ctrl_nxt),
		.bytes_left_nxt(bytes_left_nxt),
		.size_accum_nxt(size_accum_nxt),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q       <= CTRL_RESET;
			bytes_left_q <= '0;
			size_accum_q <= '0;
		end else if (go_s1) begin
			ctrl_q       <= ctrl_nxt;
			bytes_left_q <= bytes_left_nxt;
			size_accum_q <= size_accum_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			payload_q <= res.payload;
			eob_q     <= res.eob;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = payload_q;
	assign end_of_body  = eob_q;

	a_eob_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && eob_q |-> payload_q == 8'h00)
		else $error("end_of_body result carries a payload byte");

	a_eob_enters_done: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && res.valid && res.eob |=> ctrl_q.phase == PH_DONE)
		else $error("last chunk result without done phase");

	a_data_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.phase == PH_DATA |-> bytes_left_q != '0)
		else $error("data phase with no bytes left");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go_s1 |-> out_valid_q && !out_ready)
		else $error("input stage stalled with room at the output");

endmodule
`default_nettype wire
